// File: rtl/serial_line_editor_macros.svh
// Assertion helpers used by the line editor result buffer.
// Each expects ports named clock and reset in the module that uses it.
`ifndef SERIAL_LINE_EDITOR_MACROS_SVH
`define SERIAL_LINE_EDITOR_MACROS_SVH

// Same-cycle implication.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

   localparam int LINE_CHARS_DEFAULT = 200;

   // Most results one request can cause.
   localparam int RES_SLOTS = 3;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic [1:0] KIND_ECHO    = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_ABANDON = 2'd2;
   localparam logic [1:0] KIND_READ    = 2'd3;

   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_CR_LF_WAIT   = 2'd1;

   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd20000;
   localparam logic [9:0]  CR_LF_WAIT_RESET   = 10'd50;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_DEL = 8'h7F;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] line_length;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] idle_timeout;
      logic [9:0]  cr_lf_wait;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] line_length;
   } res_entry_type;

   // Results of one request; entry[0] goes out first.
   typedef struct packed {
      logic [1:0]                      count;
      logic                            from_store;
      res_entry_type [RES_SLOTS-1:0]   entry;
   } res_bundle_type;

   function automatic res_entry_type mk_entry(input logic [1:0] kind,
                                              input logic [7:0] b,
                                              input logic [7:0] len);
      res_entry_type e;
      e.kind        = kind;
      e.out_byte    = b;
      e.line_length = len;
      return e;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sle_csr.sv
`default_nettype none

module sle_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wdata,
   output sle_pkg::cfg_type     cfg
);

   sle_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout <= sle_pkg::IDLE_TIMEOUT_RESET;
         cfg_ff.cr_lf_wait   <= sle_pkg::CR_LF_WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sle_pkg::CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout <= csr_wdata;
            sle_pkg::CSR_CR_LF_WAIT:   cfg_ff.cr_lf_wait   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/sle_line_store.sv
`default_nettype none

module sle_line_store #(
   parameter int LINE_CHARS = sle_pkg::LINE_CHARS_DEFAULT,
   localparam int AW = $clog2(LINE_CHARS)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] store_mem [LINE_CHARS];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read so a stalled result stays put.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/sle_editor.sv
`default_nettype none

module sle_editor #(
   parameter int LINE_CHARS = sle_pkg::LINE_CHARS_DEFAULT,
   localparam int AW = $clog2(LINE_CHARS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sle_pkg::req_item_type req_item,
   input  wire sle_pkg::cfg_type      cfg,
   input  wire logic                  buf_free,
   output logic                       load_valid,
   output sle_pkg::res_bundle_type    bundle,
   output logic                       store_we,
   output logic [AW-1:0]              store_waddr,
   output logic [7:0]                 store_wdata,
   output logic                       store_re,
   output logic [AW-1:0]              store_raddr
);

   localparam int CW = $clog2(LINE_CHARS + 1);
   localparam logic [CW-1:0] LINE_MAX = CW'(LINE_CHARS);

   sle_pkg::req_item_type in_ff;
   logic                  in_valid_ff, in_valid_in;

   logic [CW-1:0] count_ff, count_in;
   logic          cr_ff, cr_in;
   logic [9:0]    lfw_ff, lfw_in;
   logic [15:0]   idle_ff, idle_in;
   logic          active_ff, active_in;

   logic          advance;
   logic          accept;
   logic          pre;
   logic [CW-1:0] base;
   logic [1:0]    main_n;
   logic          in_range;
   logic [7:0]    c;
   sle_pkg::res_entry_type m0, m1, m2;
   sle_pkg::res_bundle_type bundle_in;

   assign c         = in_ff.rx_byte;
   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_range  = in_ff.read_index < 8'(LINE_CHARS);

   assign store_wdata = c;
   assign store_waddr = base[AW-1:0];
   assign store_raddr = in_ff.read_index[AW-1:0];
   assign store_re    = advance && (in_ff.func == sle_pkg::FUNC_READ) && in_range;
   assign bundle      = bundle_in;
   assign load_valid  = advance && (bundle_in.count != 2'd0);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      count_in  = count_ff;
      cr_in     = cr_ff;
      lfw_in    = lfw_ff;
      idle_in   = idle_ff;
      active_in = active_ff;
      bundle_in = '0;
      store_we  = 1'b0;
      pre       = 1'b0;
      base      = count_ff;
      main_n    = 2'd0;
      m0        = '0;
      m1        = '0;
      m2        = '0;
      unique case (in_ff.func)
         sle_pkg::FUNC_BYTE: begin
            if (cr_ff && c == sle_pkg::CH_LF) begin
               // LF closes a CR: echo it, then the line end echoes another
               bundle_in.count    = 2'd3;
               bundle_in.entry[0] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
               bundle_in.entry[1] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
               bundle_in.entry[2] = sle_pkg::mk_entry(sle_pkg::KIND_DONE, 8'd0, 8'(count_ff));
               count_in  = '0;
               cr_in     = 1'b0;
               lfw_in    = '0;
               active_in = 1'b0;
            end else begin
               if (cr_ff) begin
                  // end the pending line, then treat the byte as fresh
                  pre       = 1'b1;
                  base      = '0;
                  count_in  = '0;
                  cr_in     = 1'b0;
                  lfw_in    = '0;
                  active_in = 1'b0;
               end
               if (c != sle_pkg::CH_NUL) begin
                  active_in = 1'b1;
                  idle_in   = cfg.idle_timeout;
                  if (c == sle_pkg::CH_CR) begin
                     main_n = 2'd1;
                     m0     = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 8'd0);
                     cr_in  = 1'b1;
                     lfw_in = cfg.cr_lf_wait;
                  end else if (c == sle_pkg::CH_LF) begin
                     main_n    = 2'd3;
                     m0        = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
                     m1        = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
                     m2        = sle_pkg::mk_entry(sle_pkg::KIND_DONE, 8'd0, 8'(base));
                     count_in  = '0;
                     cr_in     = 1'b0;
                     lfw_in    = '0;
                     active_in = 1'b0;
                  end else if (c == sle_pkg::CH_BS || c == sle_pkg::CH_DEL) begin
                     if (base != '0) begin
                        main_n   = 2'd3;
                        m0       = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0);
                        m1       = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_SP, 8'd0);
                        m2       = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0);
                        count_in = base - CW'(1);
                     end
                  end else if (c >= sle_pkg::CH_SP && c < sle_pkg::CH_DEL && base < LINE_MAX) begin
                     main_n   = 2'd1;
                     m0       = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, c, 8'd0);
                     store_we = advance;
                     count_in = base + CW'(1);
                  end
               end
               if (pre) begin
                  // after a line end only a single echo can follow
                  bundle_in.count    = 2'd2 + main_n;
                  bundle_in.entry[0] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
                  bundle_in.entry[1] = sle_pkg::mk_entry(sle_pkg::KIND_DONE, 8'd0, 8'(count_ff));
                  bundle_in.entry[2] = m0;
               end else begin
                  bundle_in.count    = main_n;
                  bundle_in.entry[0] = m0;
                  bundle_in.entry[1] = m1;
                  bundle_in.entry[2] = m2;
               end
            end
         end
         sle_pkg::FUNC_TICK: begin
            if (active_ff) begin
               if (idle_ff <= 16'd1) begin
                  // idle timeout wins over the CR wait
                  idle_in            = '0;
                  bundle_in.count    = 2'd3;
                  bundle_in.entry[0] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 8'd0);
                  bundle_in.entry[1] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
                  bundle_in.entry[2] = sle_pkg::mk_entry(sle_pkg::KIND_ABANDON, 8'd0, 8'd0);
                  count_in  = '0;
                  cr_in     = 1'b0;
                  lfw_in    = '0;
                  active_in = 1'b0;
               end else begin
                  idle_in = idle_ff - 16'd1;
                  if (cr_ff) begin
                     if (lfw_ff <= 10'd1) begin
                        bundle_in.count    = 2'd2;
                        bundle_in.entry[0] = sle_pkg::mk_entry(sle_pkg::KIND_ECHO, sle_pkg::CH_LF,
                                                               8'd0);
                        bundle_in.entry[1] = sle_pkg::mk_entry(sle_pkg::KIND_DONE, 8'd0,
                                                               8'(count_ff));
                        count_in  = '0;
                        cr_in     = 1'b0;
                        lfw_in    = '0;
                        active_in = 1'b0;
                     end else begin
                        lfw_in = lfw_ff - 10'd1;
                     end
                  end
               end
            end
         end
         sle_pkg::FUNC_READ: begin
            bundle_in.count      = 2'd1;
            bundle_in.from_store = in_range;
            bundle_in.entry[0]   = sle_pkg::mk_entry(sle_pkg::KIND_READ, 8'd0, 8'd0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= '0;
         cr_ff       <= 1'b0;
         lfw_ff      <= '0;
         idle_ff     <= '0;
         active_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            count_ff  <= count_in;
            cr_ff     <= cr_in;
            lfw_ff    <= lfw_in;
            idle_ff   <= idle_in;
            active_ff <= active_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/sle_result_buf.sv
`default_nettype none

`include "serial_line_editor_macros.svh"

module sle_result_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load_valid,
   input  wire sle_pkg::res_bundle_type bundle,
   input  wire logic [7:0]              store_data,
   output logic                         free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output sle_pkg::rsp_item_type        rsp_item
);

   sle_pkg::res_entry_type [sle_pkg::RES_SLOTS-1:0] slot_ff, slot_in;
   logic [1:0] count_ff, count_in;
   logic       rd_flag_ff, rd_flag_in;
   logic       consume;

   assign rsp_valid = count_ff != 2'd0;
   assign consume   = rsp_valid && !rsp_stall;
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && consume);

   assign rsp_item.kind        = slot_ff[0].kind;
   assign rsp_item.out_byte    = rd_flag_ff ? store_data : slot_ff[0].out_byte;
   assign rsp_item.line_length = slot_ff[0].line_length;
   assign rsp_item.last        = count_ff == 2'd1;

   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      rd_flag_in = rd_flag_ff;
      if (load_valid) begin
         slot_in    = bundle.entry;
         count_in   = bundle.count;
         rd_flag_in = bundle.from_store;
      end else if (consume) begin
         // advance the queue by one slot
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
         rd_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_flag_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         rd_flag_ff <= rd_flag_in;
      end
   end

   `SLE_ASSERT_NOW(a_load_when_free, load_valid, free, "load over pending results")
   `SLE_ASSERT_NOW(a_store_alone, rd_flag_ff, count_ff == 2'd1, "read result not alone")
   `SLE_ASSERT_NOW(a_abandon_last, rsp_valid && slot_ff[0].kind == sle_pkg::KIND_ABANDON, count_ff == 2'd1, "abandon not last")
   `SLE_ASSERT_NEXT(a_drain_one, consume && !load_valid, count_ff == $past(count_ff) - 2'd1, "drain miscount")

endmodule

`default_nettype wire

// File: rtl/serial_line_editor.sv
// Console line editor. One request enters per cycle on req_* unless req_stall is high: a
// received byte, a time tick or a read of the line store. Each request causes zero to three
// results, which leave on rsp_* one per cycle unless rsp_stall is high, so a request with
// several results (erase, a line end, a timeout) holds the input until its last result leaves;
// a single input register lets the next request in while a result still waits. The line store
// is a LINE_CHARS-entry memory with one write and one registered read port; entries are not
// cleared by reset and need no clearing pass. csr_ready is always high.
`default_nettype none

module serial_line_editor #(
   parameter int LINE_CHARS = sle_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sle_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sle_pkg::rsp_item_type      rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_wdata
);

   localparam int AW = $clog2(LINE_CHARS);

   sle_pkg::cfg_type        cfg;
   sle_pkg::res_bundle_type bundle;
   logic                    buf_free;
   logic                    load_valid;
   logic                    store_we;
   logic [AW-1:0]           store_waddr;
   logic [7:0]              store_wdata;
   logic                    store_re;
   logic [AW-1:0]           store_raddr;
   logic [7:0]              store_rdata;

   sle_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sle_editor #(
      .LINE_CHARS (LINE_CHARS)
   ) u_editor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .cfg         (cfg),
      .buf_free    (buf_free),
      .load_valid  (load_valid),
      .bundle      (bundle),
      .store_we    (store_we),
      .store_waddr (store_waddr),
      .store_wdata (store_wdata),
      .store_re    (store_re),
      .store_raddr (store_raddr)
   );

   sle_line_store #(
      .LINE_CHARS (LINE_CHARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_rdata)
   );

   sle_result_buf u_result (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .bundle     (bundle),
      .store_data (store_rdata),
      .free       (buf_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CHARS  = sle_pkg::LINE_CHARS_DEFAULT;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 2;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE      = 8;

   // Register settings per phase; phase 0 runs on the reset values.
   localparam int PH_IDLE [PHASES] = '{20000, 65535, 1, 7, 0, 30, 4, 16};
   localparam int PH_LF   [PHASES] = '{50, 1023, 1, 3, 0, 6, 2, 9};

   typedef struct {
      sle_pkg::req_item_type req;
      int                    n_typed;   // below zero: expectation comes from the editor model
      sle_pkg::rsp_item_type res [3];
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   sle_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   sle_pkg::rsp_item_type rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = sle_pkg::CSR_IDLE_TIMEOUT;
   logic [15:0]           csr_wdata = '0;

   serial_line_editor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Line editor model state.
   logic [7:0]   line_mem [LINE_CHARS];
   bit           mem_valid [LINE_CHARS];
   int unsigned  line_chars = 0;
   bit           cr_open = 1'b0;
   int unsigned  lf_budget = 0;
   int unsigned  idle_budget = 0;
   bit           line_open = 1'b0;
   int unsigned  idle_limit = sle_pkg::IDLE_TIMEOUT_RESET;
   int unsigned  lf_limit = sle_pkg::CR_LF_WAIT_RESET;

   sle_pkg::rsp_item_type step_res [$];
   sle_pkg::rsp_item_type rsp_due [$];
   script_row_type        script [$];

   int mismatches = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int quiet = 0;

   function automatic sle_pkg::rsp_item_type res_item(input logic [1:0] k,
                                                      input logic [7:0] b,
                                                      input logic [7:0] len, input logic l);
      sle_pkg::rsp_item_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.line_length = len;
      r.last        = l;
      return r;
   endfunction

   function automatic void note(input logic [1:0] k, input logic [7:0] b,
                                input logic [7:0] len);
      step_res.push_back(res_item(k, b, len, 1'b0));
   endfunction

   function automatic void close_line();
      note(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
      note(sle_pkg::KIND_DONE, 8'd0, 8'(line_chars));
      line_chars = 0;
      cr_open    = 1'b0;
      lf_budget  = 0;
      line_open  = 1'b0;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      if (cr_open) begin
         if (c == sle_pkg::CH_LF) begin
            note(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
            close_line();
            return;
         end
         close_line();
      end
      if (c == sle_pkg::CH_NUL) return;
      line_open   = 1'b1;
      idle_budget = idle_limit;
      if (c == sle_pkg::CH_CR) begin
         note(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 8'd0);
         cr_open   = 1'b1;
         lf_budget = lf_limit;
      end else if (c == sle_pkg::CH_LF) begin
         note(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
         close_line();
      end else if (c == sle_pkg::CH_BS || c == sle_pkg::CH_DEL) begin
         if (line_chars > 0) begin
            note(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0);
            note(sle_pkg::KIND_ECHO, sle_pkg::CH_SP, 8'd0);
            note(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0);
            line_chars--;
         end
      end else if (c >= sle_pkg::CH_SP && c < sle_pkg::CH_DEL && line_chars < LINE_CHARS) begin
         note(sle_pkg::KIND_ECHO, c, 8'd0);
         line_mem[line_chars]  = c;
         mem_valid[line_chars] = 1'b1;
         line_chars++;
      end
   endfunction

   function automatic void take_tick();
      if (!line_open) return;
      // Idle timeout wins over the CR wait.
      if (idle_budget <= 1) begin
         idle_budget = 0;
         note(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 8'd0);
         note(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0);
         note(sle_pkg::KIND_ABANDON, 8'd0, 8'd0);
         line_chars = 0;
         cr_open    = 1'b0;
         lf_budget  = 0;
         line_open  = 1'b0;
         return;
      end
      idle_budget--;
      if (cr_open) begin
         if (lf_budget <= 1) begin
            lf_budget = 0;
            close_line();
         end else begin
            lf_budget--;
         end
      end
   endfunction

   function automatic void editor_step(input sle_pkg::req_item_type it);
      step_res.delete();
      case (it.func)
         sle_pkg::FUNC_BYTE: take_char(it.rx_byte);
         sle_pkg::FUNC_TICK: take_tick();
         sle_pkg::FUNC_READ: note(sle_pkg::KIND_READ, (it.read_index < LINE_CHARS) ?
                                  line_mem[it.read_index] : 8'd0, 8'd0);
         default: ;
      endcase
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
   endfunction

   // Mostly well-formed line traffic; reads only touch entries already written.
   function automatic sle_pkg::req_item_type random_request();
      sle_pkg::req_item_type r;
      int roll;
      int at;
      r.func       = sle_pkg::FUNC_BYTE;
      r.rx_byte    = 8'($urandom);
      r.read_index = 8'($urandom_range(LINE_CHARS - 1));
      roll = $urandom_range(99);
      if (roll < 50) begin
         r.rx_byte = 8'($urandom_range(8'h7e, 8'h20));
      end else if (roll < 58) begin
         r.rx_byte = $urandom_range(1) ? sle_pkg::CH_BS : sle_pkg::CH_DEL;
      end else if (roll < 65) begin
         r.rx_byte = sle_pkg::CH_CR;
      end else if (roll < 71) begin
         r.rx_byte = sle_pkg::CH_LF;
      end else if (roll < 84) begin
         r.func = sle_pkg::FUNC_TICK;
      end else if (roll < 91) begin
         r.func = sle_pkg::FUNC_READ;
         at = r.read_index;
         while (at > 0 && !mem_valid[at]) at--;
         if (mem_valid[at]) r.read_index = 8'(at);
         else r.func = sle_pkg::FUNC_TICK;
      end else if (roll < 94) begin
         r.rx_byte = sle_pkg::CH_NUL;
      end
      return r;
   endfunction

   task automatic add_row(input logic [1:0] f, input logic [7:0] b, input logic [7:0] at,
                          input int n, input sle_pkg::rsp_item_type r0 = '0,
                          input sle_pkg::rsp_item_type r1 = '0,
                          input sle_pkg::rsp_item_type r2 = '0);
      script_row_type row;
      row.req.func       = f;
      row.req.rx_byte    = b;
      row.req.read_index = at;
      row.n_typed        = n;
      row.res[0]         = r0;
      row.res[1]         = r1;
      row.res[2]         = r2;
      script.push_back(row);
   endtask

   task automatic put_request(input script_row_type row);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= row.req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      editor_step(row.req);
      if (row.n_typed < 0) begin
         foreach (step_res[i]) rsp_due.push_back(step_res[i]);
      end else begin
         for (int i = 0; i < row.n_typed; i++) rsp_due.push_back(row.res[i]);
      end
   endtask

   task automatic send(input sle_pkg::req_item_type it);
      script_row_type row;
      row.req     = it;
      row.n_typed = -1;
      put_request(row);
   endtask

   // Drain results, then give requests without results time to leave the pipe.
   task automatic settle();
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic apply_settings(input int idle, input int lf);
      csr_valid <= 1'b1;
      csr_index <= sle_pkg::CSR_IDLE_TIMEOUT;
      csr_wdata <= 16'(idle);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= sle_pkg::CSR_CR_LF_WAIT;
      csr_wdata <= 16'(lf);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      idle_limit = idle;
      lf_limit   = lf;
   endtask

   always @(posedge clock) begin
      sle_pkg::rsp_item_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d byte %02h len %0d last %0b",
                        rsp_item.kind, rsp_item.out_byte, rsp_item.line_length,
                        rsp_item.last);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_item.kind !== want.kind || rsp_item.out_byte !== want.out_byte ||
                rsp_item.line_length !== want.line_length || rsp_item.last !== want.last)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind %0d byte %02h len %0d last %0b, %s",
                           want.kind, want.out_byte, want.line_length, want.last,
                           $sformatf("got kind %0d byte %02h len %0d last %0b",
                                     rsp_item.kind, rsp_item.out_byte,
                                     rsp_item.line_length, rsp_item.last));
            end
         end
      end
   end

   // Abort when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("serial_line_editor regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      sle_pkg::req_item_type it;
      add_row(sle_pkg::FUNC_TICK, 8'h55, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_NUL, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_BS, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, 8'h41, 8'd0, 1,
              res_item(sle_pkg::KIND_ECHO, 8'h41, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_SP, 8'd0, 1,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_SP, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, 8'h7e, 8'd0, 1,
              res_item(sle_pkg::KIND_ECHO, 8'h7e, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_DEL, 8'd0, 3,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_SP, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_BS, 8'd0, 3,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_SP, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_BS, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, 8'h01, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, 8'hff, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, 8'h80, 8'd0, 0);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF, 8'd0, 3,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_DONE, 8'd0, 8'd1, 1'b1));
      add_row(sle_pkg::FUNC_READ, 8'h00, 8'd0, 1,
              res_item(sle_pkg::KIND_READ, 8'h41, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_READ, 8'h00, 8'd2, 1,
              res_item(sle_pkg::KIND_READ, 8'h7e, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, 8'h78, 8'd0, 1,
              res_item(sle_pkg::KIND_ECHO, 8'h78, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR, 8'd0, 1,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 8'd0, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF, 8'd0, 3,
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 8'd0, 1'b0),
              res_item(sle_pkg::KIND_DONE, 8'd0, 8'd1, 1'b1));
      add_row(sle_pkg::FUNC_BYTE, 8'h79, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, 8'h7a, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_NUL, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_CR, 8'd0, -1);
      add_row(sle_pkg::FUNC_BYTE, sle_pkg::CH_LF, 8'd0, -1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            apply_settings(PH_IDLE[p], PH_LF[p]);
         end
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 76; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 76; end
            default: begin gap_pct = 15; stall_pct = 15; end
         endcase
         if (p == 0) foreach (script[i]) put_request(script[i]);
         if (p == 2) begin
            // Overfill one line, then read back its top entry.
            repeat (LINE_CHARS + 1) begin
               it = random_request();
               it.func    = sle_pkg::FUNC_BYTE;
               it.rx_byte = 8'($urandom_range(8'h7e, 8'h20));
               send(it);
            end
            it.rx_byte = sle_pkg::CH_LF;
            send(it);
            it.func       = sle_pkg::FUNC_READ;
            it.read_index = 8'(LINE_CHARS - 1);
            send(it);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(19) == 0) begin
               repeat ($urandom_range(10, 1)) begin
                  it = random_request();
                  it.func = sle_pkg::FUNC_TICK;
                  send(it);
               end
            end
            send(random_request());
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("serial_line_editor regression: pass");
      end else begin
         $display("serial_line_editor regression: fail");
      end
      $finish;
   end

endmodule
